// ===== rtl/login_record_crc32_macros.svh =====
// Assertion macros shared by the login record CRC-32 checker.
`ifndef LOGIN_RECORD_CRC32_MACROS_SVH
`define LOGIN_RECORD_CRC32_MACROS_SVH

// Same-cycle implication, sampled on aclk and quiet while aresetn is low.
`define LC32_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lc32 assertion failed");

// Next-cycle implication, sampled on aclk and quiet while aresetn is low.
`define LC32_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lc32 assertion failed");

`endif

// ===== rtl/lc32_pkg.sv =====
// Package with the record layout, login type codes and CRC-32 matrix constants.
package lc32_pkg;

    localparam int MSG_BYTES   = 18;
    localparam int SHORT_BYTES = 14;
    localparam int MSG_BITS    = 8 * MSG_BYTES;
    localparam int CRC_W       = 32;

    localparam logic [CRC_W-1:0] CRC_POLY   = 32'hEDB88320;
    localparam logic [CRC_W-1:0] CRC_INIT   = 32'hFFFFFFFF;
    localparam logic [CRC_W-1:0] FIXED_TAIL = 32'h3F57FE9B;

    localparam logic [1:0] LOGIN_REGISTER = 2'd1;
    localparam logic [1:0] LOGIN_NORMAL   = 2'd2;

    typedef logic [MSG_BITS-1:0] msg_t;
    typedef logic [CRC_W-1:0]    crc_t;
    typedef crc_t                col_array_t [MSG_BITS];

    typedef struct packed {
        logic valid;
        logic short_rec;
    } stage_ctrl_t;

    // Bytewise reflected CRC over the first nbytes of msg, first byte at the top.
    function automatic crc_t crc_bits(crc_t init, msg_t msg, int nbytes);
        crc_t       crc;
        logic [7:0] data_byte;
        crc = init;
        for (int j = 0; j < nbytes; j++) begin
            data_byte = msg[MSG_BITS-1-8*j -: 8];
            crc = crc ^ {24'd0, data_byte};
            for (int k = 0; k < 8; k++) begin
                crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
            end
        end
        return crc;
    endfunction

    // Contribution of each single message bit to the CRC register, zero preset.
    function automatic col_array_t crc_columns(int nbytes);
        col_array_t cols;
        msg_t       one_hot;
        for (int k = 0; k < MSG_BITS; k++) begin
            one_hot    = '0;
            one_hot[k] = 1'b1;
            if (k < MSG_BITS - 8 * nbytes) begin
                cols[k] = '0;
            end else begin
                cols[k] = crc_bits('0, one_hot, nbytes);
            end
        end
        return cols;
    endfunction

    localparam col_array_t COLS_LONG  = crc_columns(MSG_BYTES);
    localparam col_array_t COLS_SHORT = crc_columns(SHORT_BYTES);
    localparam crc_t BASE_LONG  = crc_bits(CRC_INIT, '0, MSG_BYTES) ^ CRC_INIT;
    localparam crc_t BASE_SHORT = crc_bits(CRC_INIT, '0, SHORT_BYTES) ^ CRC_INIT;

endpackage

// ===== rtl/lc32_in_stage.sv =====
// Input register stage that serializes a login record into its byte stream.
module lc32_in_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [31:0]          s_code_bytes,
    input  logic [31:0]          s_account_id,
    input  logic [47:0]          s_mac_address,
    input  logic [31:0]          s_lan_ip,
    input  logic [1:0]           s_login_type,
    input  logic                 adv_ready,
    output lc32_pkg::msg_t       msg_reg,
    output lc32_pkg::stage_ctrl_t ctrl_reg
);
    import lc32_pkg::*;

    msg_t             msg_next;
    logic [CRC_W-1:0] tail;
    logic             short_next;

    assign s_ready = !ctrl_reg.valid || adv_ready;

    always_comb begin
        tail       = (s_login_type == LOGIN_NORMAL) ? ~s_lan_ip : FIXED_TAIL;
        msg_next   = {s_code_bytes, s_account_id, s_mac_address, tail};
        short_next = (s_login_type == LOGIN_REGISTER);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else begin
            if (s_ready) begin
                ctrl_reg.valid <= s_valid;
            end
            if (s_valid && s_ready) begin
                ctrl_reg.short_rec <= short_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            msg_reg <= msg_next;
        end
    end

endmodule

// ===== rtl/lc32_crc_core.sv =====
// Parallel CRC-32 XOR network over a 14-byte or 18-byte record.
module lc32_crc_core (
    input  lc32_pkg::msg_t msg,
    input  logic           short_rec,
    output lc32_pkg::crc_t crc
);
    import lc32_pkg::*;

    always_comb begin
        crc_t acc_long;
        crc_t acc_short;
        acc_long  = BASE_LONG;
        acc_short = BASE_SHORT;
        for (int k = 0; k < MSG_BITS; k++) begin
            if (msg[k]) begin
                acc_long  = acc_long ^ COLS_LONG[k];
                acc_short = acc_short ^ COLS_SHORT[k];
            end
        end
        crc = short_rec ? acc_short : acc_long;
    end

endmodule

// ===== rtl/login_record_crc32.sv =====
// Login record CRC-32 top level: returns the reflected CRC-32 of one login record per
// transaction. A record is accepted every cycle unless the output stalls; it passes
// through the input register, where the record is laid out as its 14-byte or
// 18-byte stream, and then through the parallel XOR network of the 144 message bits into
// the result register. While a result waits for m_ready, the input register still takes
// one more record, and s_ready drops once both registers hold a record.
module login_record_crc32 (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_code_bytes,
    input  logic [31:0] s_account_id,
    input  logic [47:0] s_mac_address,
    input  logic [31:0] s_lan_ip,
    input  logic [1:0]  s_login_type,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_crc_value
);
    import lc32_pkg::*;

    msg_t        stage_msg;
    stage_ctrl_t stage_ctrl;
    logic        adv_ready;
    crc_t        crc_next;
    crc_t        crc_reg;
    logic        m_valid_reg;

    assign adv_ready   = !m_valid_reg || m_ready;
    assign m_valid     = m_valid_reg;
    assign m_crc_value = crc_reg;

    lc32_in_stage u_in_stage (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_code_bytes  (s_code_bytes),
        .s_account_id  (s_account_id),
        .s_mac_address (s_mac_address),
        .s_lan_ip      (s_lan_ip),
        .s_login_type  (s_login_type),
        .adv_ready     (adv_ready),
        .msg_reg       (stage_msg),
        .ctrl_reg      (stage_ctrl)
    );

    lc32_crc_core u_crc_core (
        .msg       (stage_msg),
        .short_rec (stage_ctrl.short_rec),
        .crc       (crc_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv_ready) begin
            m_valid_reg <= stage_ctrl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_ready && stage_ctrl.valid) begin
            crc_reg <= crc_next;
        end
    end

endmodule

// ===== rtl/lc32_checker.sv =====
// Port-level checker for the login record CRC-32 block, bound to the top level.
`include "login_record_crc32_macros.svh"

module lc32_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_crc_value
);

    // A stalled result keeps its value until it is taken.
    `LC32_ASSERT_NEXT(a_result_holds, m_valid && !m_ready, m_valid && $stable(m_crc_value))

    // The input side backs up only when both pipeline registers are full.
    `LC32_ASSERT_NOW(a_ready_only_when_full, !s_ready, m_valid && !m_ready)

    // A new result follows a transaction that passed through the input register into the result register.
    `LC32_ASSERT_NOW(a_result_latency, $rose(m_valid), $past(s_valid && s_ready, 2))

endmodule

bind login_record_crc32 lc32_checker u_lc32_checker (.*);

// ===== tb/tb_login_record_crc32.sv =====
// Self-checking testbench for the login record CRC-32 block with random flow control.
`timescale 1ns / 1ps

module tb_login_record_crc32;

    import lc32_pkg::LOGIN_REGISTER;
    import lc32_pkg::LOGIN_NORMAL;
    import lc32_pkg::FIXED_TAIL;

    localparam logic [31:0] CRC32_POLY   = 32'hEDB88320;
    localparam int          RANDOM_ITEMS = 1100;
    localparam int          SEGMENT_LEN  = 100;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          STALL_LIMIT  = 2000;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          MAX_REPORTS  = 10;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_code_bytes;
    logic [31:0] s_account_id;
    logic [47:0] s_mac_address;
    logic [31:0] s_lan_ip;
    logic [1:0]  s_login_type;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_crc_value;

    logic [31:0] crc_expected[$];
    int          mismatch_count = 0;
    int          idle_cycles    = 0;
    bit          sender_steady   = 1'b0;
    bit          receiver_steady = 1'b0;
    bit          hold_request    = 1'b0;

    login_record_crc32 dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_code_bytes  (s_code_bytes),
        .s_account_id  (s_account_id),
        .s_mac_address (s_mac_address),
        .s_lan_ip      (s_lan_ip),
        .s_login_type  (s_login_type),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_crc_value   (m_crc_value)
    );

    always #5 aclk = ~aclk;

    function automatic logic [31:0] crc_feed_byte(logic [31:0] crc, logic [7:0] data);
        logic [31:0] reg_val;
        reg_val = crc ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            reg_val = reg_val[0] ? ((reg_val >> 1) ^ CRC32_POLY) : (reg_val >> 1);
        end
        return reg_val;
    endfunction

    function automatic logic [31:0] record_crc(logic [31:0] code, logic [31:0] id,
                                               logic [47:0] mac, logic [31:0] lan,
                                               logic [1:0] ltype);
        logic [143:0] stream;
        logic [31:0]  tail;
        logic [31:0]  crc;
        int           nbytes;
        tail   = (ltype == LOGIN_NORMAL) ? ~lan : FIXED_TAIL;
        stream = {code, id, mac, tail};
        nbytes = (ltype == LOGIN_REGISTER) ? 14 : 18;
        crc    = 32'hFFFFFFFF;
        for (int j = 0; j < nbytes; j++) begin
            crc = crc_feed_byte(crc, stream[143 - 8 * j -: 8]);
        end
        return ~crc;
    endfunction

    task automatic send_record(input logic [31:0] code, input logic [31:0] id,
                               input logic [47:0] mac, input logic [31:0] lan,
                               input logic [1:0] ltype);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_code_bytes  <= code;
        s_account_id  <= id;
        s_mac_address <= mac;
        s_lan_ip      <= lan;
        s_login_type  <= ltype;
        do @(posedge aclk); while (s_ready !== 1'b1);
    endtask

    function automatic logic [47:0] random_field(int width);
        logic [63:0] raw;
        logic [47:0] mask;
        raw  = {$urandom, $urandom};
        mask = (width == 48) ? 48'hFFFF_FFFF_FFFF : 48'h0000_FFFF_FFFF;
        case ($urandom_range(0, 7))
            0: return '0;
            1: return mask;
            default: return raw[47:0] & mask;
        endcase
    endfunction

    task automatic test_directed();
        for (int t = 0; t < 4; t++) begin
            send_record('0, '0, '0, '0, 2'(t));
            send_record('1, '1, '1, '1, 2'(t));
        end
        send_record(32'hAAAAAAAA, 32'h55555555, 48'hAAAA_AAAA_AAAA, 32'h55555555, LOGIN_NORMAL);
        send_record(32'h55555555, 32'hAAAAAAAA, 48'h5555_5555_5555, 32'hAAAAAAAA, LOGIN_NORMAL);
        send_record(32'h80000000, 32'h00000001, 48'h8000_0000_0001, 32'h0, LOGIN_REGISTER);
        send_record(32'h00000001, 32'h80000000, 48'h0000_0000_0001, 32'h80000000, 2'd3);
        send_record(32'h01234567, 32'h89ABCDEF, 48'h0011_2233_4455, 32'hC0A80001, LOGIN_NORMAL);
        send_record(32'h01234567, 32'h89ABCDEF, 48'h0011_2233_4455, 32'hC0A80001, 2'd0);
        send_record(32'h01234567, 32'h89ABCDEF, 48'h0011_2233_4455, 32'hC0A80001, LOGIN_REGISTER);
        send_record(32'h0, 32'h0, 48'h0, 32'hFFFFFFFF, LOGIN_NORMAL);
        send_record(32'h0, 32'h0, 48'h0, 32'h00000000, LOGIN_NORMAL);
        send_record(32'hFFFFFFFF, 32'h0, 48'hFFFF_FFFF_FFFF, 32'h0, LOGIN_REGISTER);
    endtask

    task automatic test_backpressure();
        sender_steady = 1'b1;
        hold_request  = 1'b1;
        for (int i = 0; i < 30; i++) begin
            send_record(32'(random_field(32)), 32'(random_field(32)), random_field(48),
                        32'(random_field(32)), 2'($urandom_range(0, 3)));
        end
        sender_steady = 1'b0;
    endtask

    task automatic test_random();
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % SEGMENT_LEN == 0) begin
                case ((i / SEGMENT_LEN == 1) ? 0 : $urandom_range(0, 3))
                    0: begin
                        sender_steady   = 1'b1;
                        receiver_steady = 1'b1;
                    end
                    1: begin
                        sender_steady   = 1'b1;
                        receiver_steady = 1'b0;
                    end
                    2: begin
                        sender_steady   = 1'b0;
                        receiver_steady = 1'b1;
                    end
                    default: begin
                        sender_steady   = 1'b0;
                        receiver_steady = 1'b0;
                    end
                endcase
            end
            send_record(32'(random_field(32)), 32'(random_field(32)), random_field(48),
                        32'(random_field(32)), 2'($urandom_range(0, 3)));
        end
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
    endtask

    // Result receiver: random stalls, plus one long hold-off on request.
    initial begin
        int stall;
        m_ready <= 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            stall = receiver_steady ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            crc_expected.push_back(record_crc(s_code_bytes, s_account_id, s_mac_address,
                                              s_lan_ip, s_login_type));
        end
    end

    always @(posedge aclk) begin
        logic [31:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (crc_expected.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("Unexpected result transaction: crc_value %h", m_crc_value);
                end
            end else begin
                want = crc_expected.pop_front();
                if (m_crc_value !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("crc_value mismatch: expected %h, actual %h",
                                 want, m_crc_value);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && ((s_valid && s_ready) || (m_valid && m_ready))) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("tb_login_record_crc32 failed");
                $finish;
            end
        end
    end

    initial begin
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_code_bytes  <= '0;
        s_account_id  <= '0;
        s_mac_address <= '0;
        s_lan_ip      <= '0;
        s_login_type  <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_backpressure();
        test_random();
        s_valid <= 1'b0;

        @(posedge aclk);
        while (crc_expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("tb_login_record_crc32 passed");
        end else begin
            $display("tb_login_record_crc32 failed");
        end
        $finish;
    end

endmodule
